/* rtl/wsfd_pkg.sv */
// wsfd_pkg: shared types and constants for the websocket frame deframer
// used by wsfd_parser and websocket_frame_deframer, no dependencies

package wsfd_pkg;

    // header parse phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LEN     = 3'd1,
        PH_EXT_HI  = 3'd2,
        PH_EXT_LO  = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DROP    = 3'd6
    } phase_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_REJECT  = 2'd2
    } kind_t;

    // 7-bit length codes that escape to extended lengths
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [1:0] KEY_LAST = 2'd3;

    // one result beat as produced by the parser
    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  data;
        logic        last;
        logic [15:0] length;
    } result_t;

endpackage

/* rtl/wsfd_parser.sv */
// wsfd_parser: frame header parser state and per-byte unmasking
// depends on wsfd_pkg

module wsfd_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [7:0]         in_byte,
    input  logic               frame_start,
    output wsfd_pkg::result_t  result
);

    wsfd_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      flen_reg, flen_next;
    logic [15:0]      rem_reg, rem_next;
    logic             mask_reg, mask_next;
    logic [3:0][7:0]  key_reg, key_next;
    logic [1:0]       kidx_reg, kidx_next;

    logic             known;
    logic [15:0]      known_len;
    logic             known_mask;
    logic [6:0]       len7;
    logic [15:0]      rem_dec;

    assign len7    = in_byte[6:0];
    assign rem_dec = rem_reg - 16'd1;

    always_comb begin
        phase_next = phase_reg;
        flen_next  = flen_reg;
        rem_next   = rem_reg;
        mask_next  = mask_reg;
        key_next   = key_reg;
        kidx_next  = kidx_reg;
        known      = 1'b0;
        known_len  = flen_reg;
        known_mask = mask_reg;
        result     = '0;
        result.kind = wsfd_pkg::KIND_PAYLOAD;

        if (frame_start) begin
            phase_next = wsfd_pkg::PH_LEN;
            flen_next  = '0;
            rem_next   = '0;
            mask_next  = 1'b0;
            kidx_next  = '0;
        end else begin
            unique case (phase_reg)
                wsfd_pkg::PH_LEN: begin
                    mask_next = in_byte[7];
                    if (len7 == wsfd_pkg::LEN_EXT64) begin
                        phase_next   = wsfd_pkg::PH_DROP;
                        flen_next    = '0;
                        result.valid = 1'b1;
                        result.kind  = wsfd_pkg::KIND_REJECT;
                        result.last  = 1'b1;
                    end else if (len7 == wsfd_pkg::LEN_EXT16) begin
                        phase_next = wsfd_pkg::PH_EXT_HI;
                    end else begin
                        flen_next  = {9'd0, len7};
                        known      = 1'b1;
                        known_len  = {9'd0, len7};
                        known_mask = in_byte[7];
                    end
                end
                wsfd_pkg::PH_EXT_HI: begin
                    flen_next  = {in_byte, 8'h00};
                    phase_next = wsfd_pkg::PH_EXT_LO;
                end
                wsfd_pkg::PH_EXT_LO: begin
                    flen_next  = {flen_reg[15:8], in_byte};
                    known      = 1'b1;
                    known_len  = {flen_reg[15:8], in_byte};
                    known_mask = mask_reg;
                end
                wsfd_pkg::PH_KEY: begin
                    key_next[kidx_reg] = in_byte;
                    if (kidx_reg == wsfd_pkg::KEY_LAST) begin
                        kidx_next = '0;
                        if (flen_reg == 16'd0) begin
                            phase_next   = wsfd_pkg::PH_IDLE;
                            result.valid = 1'b1;
                            result.kind  = wsfd_pkg::KIND_EMPTY;
                            result.last  = 1'b1;
                        end else begin
                            rem_next   = flen_reg;
                            phase_next = wsfd_pkg::PH_PAYLOAD;
                        end
                    end else begin
                        kidx_next = kidx_reg + 2'd1;
                    end
                end
                wsfd_pkg::PH_PAYLOAD: begin
                    kidx_next     = kidx_reg + 2'd1;
                    rem_next      = rem_dec;
                    result.valid  = 1'b1;
                    result.kind   = wsfd_pkg::KIND_PAYLOAD;
                    result.data   = mask_reg ? (in_byte ^ key_reg[kidx_reg]) : in_byte;
                    result.last   = (rem_dec == 16'd0);
                    result.length = flen_reg;
                    if (rem_dec == 16'd0) begin
                        phase_next = wsfd_pkg::PH_IDLE;
                    end
                end
                wsfd_pkg::PH_IDLE, wsfd_pkg::PH_DROP: begin
                    // bytes outside a frame are dropped
                end
                default: begin
                    phase_next = wsfd_pkg::PH_IDLE;
                end
            endcase

            // length settled: go to key, empty-frame result or payload
            if (known) begin
                kidx_next = '0;
                if (known_mask) begin
                    phase_next = wsfd_pkg::PH_KEY;
                end else if (known_len == 16'd0) begin
                    phase_next   = wsfd_pkg::PH_IDLE;
                    result.valid = 1'b1;
                    result.kind  = wsfd_pkg::KIND_EMPTY;
                    result.last  = 1'b1;
                end else begin
                    rem_next   = known_len;
                    phase_next = wsfd_pkg::PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= wsfd_pkg::PH_IDLE;
            flen_reg  <= '0;
            rem_reg   <= '0;
            mask_reg  <= 1'b0;
            key_reg   <= '0;
            kidx_reg  <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            flen_reg  <= flen_next;
            rem_reg   <= rem_next;
            mask_reg  <= mask_next;
            key_reg   <= key_next;
            kidx_reg  <= kidx_next;
        end
    end

endmodule

/* rtl/websocket_frame_deframer.sv */
// websocket_frame_deframer: top level, byte-serial frame parser with unmasking
// depends on wsfd_pkg and wsfd_parser
//
//  channel | dir | handshake          | beat payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_valid / s_ready  | s_in_byte, s_frame_start
//  m_      | out | m_valid / m_ready  | m_kind, m_out_byte, m_last_of_frame,
//          |     |                    | m_payload_length
//
// one input beat per cycle while s_ready is high; each beat yields zero or one result beat
// a result beat is registered once: the parser state update and xor sit ahead
// of the output register, which is the only pipeline stage
// s_ready stays high while the output register is empty or being drained,
// so a steady m_ready gives full rate; a stalled output holds its beat
// reset (aresetn low, synchronous) returns the parser to waiting for a
// frame start and empties the output register

module websocket_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_frame_start,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_out_byte,
    output logic        m_last_of_frame,
    output logic [15:0] m_payload_length
);

    logic              in_beat;
    wsfd_pkg::result_t res;

    logic              out_valid_reg, out_valid_next;
    wsfd_pkg::result_t out_reg;

    // accept when the output slot is free or emptying this cycle
    assign s_ready = !out_valid_reg || m_ready;
    assign in_beat = s_valid && s_ready;

    wsfd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (in_beat),
        .in_byte     (s_in_byte),
        .frame_start (s_frame_start),
        .result      (res)
    );

    // output slot fills on a result, holds while stalled
    assign out_valid_next = (in_beat && res.valid) || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (in_beat && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_reg.kind;
    assign m_out_byte       = out_reg.data;
    assign m_last_of_frame  = out_reg.last;
    assign m_payload_length = out_reg.length;

endmodule
